// ----- sv/gaussian_elimination_solver_core_macros.svh -----
// Assertion macros for the Gaussian elimination solver core.
// Used by the top level; depends on clock and reset names of the including module.
`ifndef GAUSSIAN_ELIMINATION_SOLVER_CORE_MACROS_SVH
`define GAUSSIAN_ELIMINATION_SOLVER_CORE_MACROS_SVH

// condition holds at every edge outside reset
`define GES_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define GES_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/ges_pkg.sv -----
// Shared types and constants for the Gaussian elimination solver core.
// No dependencies.
package ges_pkg;

   localparam int SIZE        = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int ROW_W       = 4;
   localparam int COL_W       = 5;
   localparam int ADDR_W      = ROW_W + COL_W;
   localparam int QUOT_W      = VALUE_WIDTH + FRAC_BITS;

   localparam logic STATUS_SOLVED     = 1'b0;
   localparam logic STATUS_ZERO_PIVOT = 1'b1;

   typedef struct packed {
      logic [ROW_W-1:0]              row_index;
      logic [COL_W-1:0]              col_index;
      logic signed [VALUE_WIDTH-1:0] entry_value;
      logic                          start_solve;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]              solution_index;
      logic signed [VALUE_WIDTH-1:0] solution_value;
      logic                          status;
      logic                          last_result;
   } rsp_type;

endpackage

// ----- sv/gaussian_elimination_solver_core.sv -----
// Solves A x = b (16x16, signed Q16.16) by elimination without pivoting and back
// substitution. The block takes entries only while no solve runs. A transfer
// with start_solve writes its entry and starts the solve: every update goes
// through the single coefficient memory in read, multiply, write order, and every
// multiplier and unknown takes a bit-serial divide. Unknowns come out from index
// 15 down to 0, the last one flagged; a zero pivot instead gives one result with
// status set. A and b must be loaded before use.
`include "gaussian_elimination_solver_core_macros.svh"

module gaussian_elimination_solver_core
   import ges_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam logic [COL_W-1:0] RHS_COL = COL_W'(SIZE);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SIZE - 1);
   localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam int CNT_W = $clog2(QUOT_W);

   typedef enum logic [3:0] {
      S_IDLE, S_PIV, S_PIVW, S_LRD, S_LWAIT, S_FDIV, S_FRD, S_FMUL, S_FWR,
      S_BRD, S_BMUL, S_BACC, S_BDLOAD, S_BDIV, S_OUT
   } state_type;

   function automatic logic signed [VALUE_WIDTH-1:0] sat_sub(
      input logic signed [VALUE_WIDTH-1:0] a, input logic signed [VALUE_WIDTH-1:0] b);
      logic signed [VALUE_WIDTH:0] d;
      d = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
      if (d[VALUE_WIDTH] != d[VALUE_WIDTH-1]) return d[VALUE_WIDTH] ? VMIN : VMAX;
      return d[VALUE_WIDTH-1:0];
   endfunction

   function automatic logic signed [VALUE_WIDTH-1:0] sat_add(
      input logic signed [VALUE_WIDTH-1:0] a, input logic signed [VALUE_WIDTH-1:0] b);
      logic signed [VALUE_WIDTH:0] s;
      s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
      if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) return s[VALUE_WIDTH] ? VMIN : VMAX;
      return s[VALUE_WIDTH-1:0];
   endfunction

   // scale a full product back to Q16.16, truncating toward zero, saturating
   function automatic logic signed [VALUE_WIDTH-1:0] fx_scale(
      input logic signed [2*VALUE_WIDTH-1:0] p);
      logic signed [2*VALUE_WIDTH-1:0] t;
      logic signed [2*VALUE_WIDTH-1:0] s;
      t = p[2*VALUE_WIDTH-1] ? p + (2*VALUE_WIDTH)'((1 << FRAC_BITS) - 1) : p;
      s = t >>> FRAC_BITS;
      if (s > (2*VALUE_WIDTH)'(VMAX)) return VMAX;
      if (s < $signed({{VALUE_WIDTH{1'b1}}, VMIN})) return VMIN;
      return s[VALUE_WIDTH-1:0];
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] mag(input logic signed [VALUE_WIDTH-1:0] v);
      return v[VALUE_WIDTH-1] ? VALUE_WIDTH'(-v) : v;
   endfunction

   state_type state_ff, state_in;
   logic [ROW_W-1:0] k_ff, k_in, i_ff, i_in;
   logic [COL_W-1:0] j_ff, j_in;
   logic signed [VALUE_WIDTH-1:0] piv_ff, piv_in, l_ff, l_in, acc_ff, acc_in;
   logic signed [2*VALUE_WIDTH-1:0] prod_ff, prod_in;
   logic [QUOT_W-1:0] div_num_ff, div_num_in, div_q_ff, div_q_in;
   logic [VALUE_WIDTH-1:0] div_den_ff, div_den_in, div_rem_ff, div_rem_in;
   logic [CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic div_neg_ff, div_neg_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // memories
   logic signed [VALUE_WIDTH-1:0] coef_mem [MEM_DEPTH];
   logic signed [VALUE_WIDTH-1:0] sol_mem [SIZE];
   logic signed [VALUE_WIDTH-1:0] rd_a_ff, rd_b_ff, sol_rd_ff;
   logic rd_en, mem_we, sol_we;
   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
   logic signed [VALUE_WIDTH-1:0] wr_data;
   logic [ROW_W-1:0] sol_rd_addr;

   // divider step
   logic [VALUE_WIDTH:0] rem_sh;
   logic [VALUE_WIDTH-1:0] rem_nxt;
   logic [QUOT_W-1:0] q_nxt;
   logic signed [VALUE_WIDTH-1:0] q_sat;
   logic req_xfer;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      rem_sh = {div_rem_ff, div_num_ff[QUOT_W-1]};
      if (rem_sh >= {1'b0, div_den_ff}) begin
         rem_nxt = VALUE_WIDTH'(rem_sh - {1'b0, div_den_ff});
         q_nxt   = {div_q_ff[QUOT_W-2:0], 1'b1};
      end else begin
         rem_nxt = rem_sh[VALUE_WIDTH-1:0];
         q_nxt   = {div_q_ff[QUOT_W-2:0], 1'b0};
      end
      if (q_nxt[QUOT_W-1:VALUE_WIDTH-1] != '0) q_sat = div_neg_ff ? VMIN : VMAX;
      else if (div_neg_ff) q_sat = -$signed(q_nxt[VALUE_WIDTH-1:0]);
      else q_sat = $signed(q_nxt[VALUE_WIDTH-1:0]);
   end

   always_comb begin
      state_in = state_ff;
      k_in = k_ff; i_in = i_ff; j_in = j_ff;
      piv_in = piv_ff; l_in = l_ff; acc_in = acc_ff; prod_in = prod_ff;
      div_num_in = div_num_ff; div_q_in = div_q_ff; div_den_in = div_den_ff;
      div_rem_in = div_rem_ff; div_cnt_in = div_cnt_ff; div_neg_in = div_neg_ff;
      rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      rd_en = 1'b0; mem_we = 1'b0; sol_we = 1'b0;
      rd_addr_a = '0; rd_addr_b = '0; wr_addr = '0; wr_data = '0; sol_rd_addr = '0;

      unique case (state_ff)
         S_IDLE: begin
            wr_addr = {req_data.row_index, req_data.col_index};
            wr_data = req_data.entry_value;
            if (req_xfer) begin
               mem_we = ({1'b0, req_data.row_index} < (ROW_W+1)'(SIZE))
                        && (req_data.col_index <= RHS_COL);
               if (req_data.start_solve) begin
                  k_in = '0;
                  state_in = S_PIV;
               end
            end
         end
         S_PIV: begin
            rd_en = 1'b1;
            rd_addr_a = {k_ff, COL_W'(k_ff)};
            state_in = S_PIVW;
         end
         S_PIVW: begin
            piv_in = rd_a_ff;
            if (rd_a_ff == '0) begin
               rsp_in = '{solution_index: '0, solution_value: '0,
                          status: STATUS_ZERO_PIVOT, last_result: 1'b1};
               rsp_valid_in = 1'b1;
               state_in = S_OUT;
            end else if (k_ff == LAST_ROW) begin
               i_in = LAST_ROW;
               j_in = RHS_COL;
               acc_in = '0;
               state_in = S_BRD;
            end else begin
               i_in = k_ff + 1'b1;
               state_in = S_LRD;
            end
         end
         S_LRD: begin
            rd_en = 1'b1;
            rd_addr_a = {i_ff, COL_W'(k_ff)};
            state_in = S_LWAIT;
         end
         S_LWAIT: begin
            div_neg_in = rd_a_ff[VALUE_WIDTH-1] ^ piv_ff[VALUE_WIDTH-1];
            div_num_in = {mag(rd_a_ff), {FRAC_BITS{1'b0}}};
            div_den_in = mag(piv_ff);
            div_rem_in = '0; div_q_in = '0;
            div_cnt_in = CNT_W'(QUOT_W - 1);
            state_in = S_FDIV;
         end
         S_FDIV: begin
            div_rem_in = rem_nxt; div_q_in = q_nxt;
            div_num_in = {div_num_ff[QUOT_W-2:0], 1'b0};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               l_in = q_sat;
               j_in = COL_W'(k_ff) + 1'b1;
               state_in = S_FRD;
            end
         end
         S_FRD: begin
            rd_en = 1'b1;
            rd_addr_a = {k_ff, j_ff};
            rd_addr_b = {i_ff, j_ff};
            state_in = S_FMUL;
         end
         S_FMUL: begin
            prod_in = l_ff * rd_a_ff;
            state_in = S_FWR;
         end
         S_FWR: begin
            mem_we = 1'b1;
            wr_addr = {i_ff, j_ff};
            wr_data = sat_sub(rd_b_ff, fx_scale(prod_ff));
            if (j_ff == RHS_COL) begin
               if (i_ff == LAST_ROW) begin
                  k_in = k_ff + 1'b1;
                  state_in = S_PIV;
               end else begin
                  i_in = i_ff + 1'b1;
                  state_in = S_LRD;
               end
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_FRD;
            end
         end
         S_BRD: begin
            rd_en = 1'b1;
            sol_rd_addr = j_ff[ROW_W-1:0];
            rd_addr_b = {i_ff, COL_W'(i_ff)};
            if (j_ff == RHS_COL) begin
               rd_addr_a = {i_ff, RHS_COL};
               state_in = S_BDLOAD;
            end else begin
               rd_addr_a = {i_ff, j_ff};
               state_in = S_BMUL;
            end
         end
         S_BMUL: begin
            prod_in = rd_a_ff * sol_rd_ff;
            state_in = S_BACC;
         end
         S_BACC: begin
            acc_in = sat_add(acc_ff, fx_scale(prod_ff));
            j_in = j_ff + 1'b1;
            state_in = S_BRD;
         end
         S_BDLOAD: begin
            div_num_in = {mag(sat_sub(rd_a_ff, acc_ff)), {FRAC_BITS{1'b0}}};
            div_neg_in = sat_sub(rd_a_ff, acc_ff) < 0 ? ~rd_b_ff[VALUE_WIDTH-1]
                                                       : rd_b_ff[VALUE_WIDTH-1];
            div_den_in = mag(rd_b_ff);
            div_rem_in = '0; div_q_in = '0;
            div_cnt_in = CNT_W'(QUOT_W - 1);
            state_in = S_BDIV;
         end
         S_BDIV: begin
            div_rem_in = rem_nxt; div_q_in = q_nxt;
            div_num_in = {div_num_ff[QUOT_W-2:0], 1'b0};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               sol_we = 1'b1;
               rsp_in = '{solution_index: i_ff, solution_value: q_sat,
                          status: STATUS_SOLVED, last_result: (i_ff == '0)};
               rsp_valid_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold the result until the transfer completes
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.last_result) begin
                  state_in = S_IDLE;
               end else begin
                  j_in = COL_W'(i_ff);
                  i_in = i_ff - 1'b1;
                  acc_in = '0;
                  state_in = S_BRD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff <= k_in; i_ff <= i_in; j_ff <= j_in;
      piv_ff <= piv_in; l_ff <= l_in; acc_ff <= acc_in; prod_ff <= prod_in;
      div_num_ff <= div_num_in; div_q_ff <= div_q_in; div_den_ff <= div_den_in;
      div_rem_ff <= div_rem_in; div_cnt_ff <= div_cnt_in; div_neg_ff <= div_neg_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) coef_mem[wr_addr] <= wr_data;
      if (rd_en) begin
         rd_a_ff <= coef_mem[rd_addr_a];
         rd_b_ff <= coef_mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (sol_we) sol_mem[i_ff] <= q_sat;
      if (rd_en) sol_rd_ff <= sol_mem[sol_rd_addr];
   end

   `GES_ASSERT_ALWAYS(a_load_excl_result, !(req_ready && rsp_valid), "entry taken during result")
   `GES_ASSERT_NEXT(a_last_to_idle, rsp_valid && rsp_ready && rsp_data.last_result, req_ready, "no idle after last result")
   `GES_ASSERT_ALWAYS(a_error_single, !(rsp_valid && rsp_data.status) || (rsp_data.last_result && rsp_data.solution_index == '0), "error result not final")

endmodule
